>>> rtl/core/wtd_pkg.sv
// Package for the wheel-30 trial-division prime test.
// Holds the value width, the sequencer state and stage types, the divider
// handshake structs and the wheel gap table. No dependencies.
package wtd_pkg;

  localparam int VALUE_W = 64;
  localparam int CNT_W   = $clog2(VALUE_W + 1);
  localparam int GAP_W   = 3;

  localparam int WHEEL_SPAN  = 30;
  localparam int FIRST_WHEEL = 7;

  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_FIN
  } state_t;

  // which trial divisor set the sequencer is working through
  typedef enum logic [1:0] {
    SG_BY2,
    SG_BY3,
    SG_BY5,
    SG_WHEEL
  } stage_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // gaps between successive divisors coprime to 30, starting at 7
  function automatic logic [GAP_W:0] wheel_gap(input logic [GAP_W-1:0] k);
    logic [GAP_W:0] g;
    case (k)
      3'd0:    g = 4'd4;
      3'd1:    g = 4'd2;
      3'd2:    g = 4'd4;
      3'd3:    g = 4'd2;
      3'd4:    g = 4'd4;
      3'd5:    g = 4'd6;
      3'd6:    g = 4'd2;
      3'd7:    g = 4'd6;
      default: g = 4'd2;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/core/wtd_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all trials.
// Depends on wtd_pkg for the value width and the handshake structs.
module wtd_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  wtd_pkg::div_ctl_t ctl,
  input  wtd_pkg::value_t   dividend,
  input  wtd_pkg::value_t   divisor,
  output wtd_pkg::div_sts_t sts,
  output wtd_pkg::value_t   quotient,
  output wtd_pkg::value_t   remainder
);
  import wtd_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  value_t           quo_r, quo_nxt;
  value_t           rem_r, rem_nxt;
  value_t           dsr_r, dsr_nxt;
  logic [VALUE_W:0] trial;
  logic             ge;

  assign trial = {rem_r, quo_r[VALUE_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (ctl.start) begin
      cnt_nxt = CNT_W'(VALUE_W);
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[VALUE_W-2:0], ge};
      rem_nxt = ge ? VALUE_W'(trial - {1'b0, dsr_r}) : trial[VALUE_W-1:0];
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy  = cnt_r != '0;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> rtl/core/wheel_trial_division_prime_test.sv
// Values up to 3 and 5 strobe out_strobe in the cycle after the accepting edge;
// else each trial division is load, one quotient bit a cycle, decide, then the
// result strobe; trials: 2, 3, 5, then wheel-30 divisors up to the square root.
// Throughput: one beat at a time; busy stays high through the result strobe.
// The result is shown for one cycle on out_strobe; the receiver cannot stall.
// Reset (rst_n low, synchronous) returns the sequencer to idle at once.
module wheel_trial_division_prime_test (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  wtd_pkg::value_t in_value,
  output logic            out_strobe,
  output logic            out_is_prime
);
  import wtd_pkg::*;

  state_t         state_r, state_nxt;
  stage_t         stage_r, stage_nxt;
  value_t         n_r, n_nxt;
  value_t         d_r, d_nxt;
  logic [GAP_W-1:0] k_r, k_nxt;
  logic           res_r, res_nxt;

  div_ctl_t       div_ctl;
  div_sts_t       div_sts;
  value_t         div_q, div_rem, divisor;

  logic           accept, direct;
  logic           ev_fin, ev_prime;
  logic           r_zero, past_root;

  assign accept = start && !busy;
  assign direct = (in_value <= VALUE_W'(3)) || (in_value == VALUE_W'(5));

  always_comb begin
    case (stage_r)
      SG_BY2:   divisor = VALUE_W'(2);
      SG_BY3:   divisor = VALUE_W'(3);
      SG_BY5:   divisor = VALUE_W'(5);
      default:  divisor = d_r;
    endcase
  end

  wtd_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (n_r),
    .divisor   (divisor),
    .sts       (div_sts),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign r_zero    = div_rem == '0;
  assign past_root = d_r > div_q;

  // decision on a finished division
  always_comb begin
    ev_fin   = 1'b0;
    ev_prime = 1'b0;
    case (stage_r)
      SG_BY2, SG_BY3: begin
        ev_fin = r_zero;
      end
      SG_BY5: begin
        if (r_zero) begin
          ev_fin = 1'b1;
        end else if (n_r <= VALUE_W'(WHEEL_SPAN)) begin
          // coprime to 30 and below 31: always one of the small primes
          ev_fin   = 1'b1;
          ev_prime = 1'b1;
        end
      end
      default: begin
        if (past_root) begin
          ev_fin   = 1'b1;
          ev_prime = 1'b1;
        end else if (r_zero) begin
          ev_fin = 1'b1;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = direct ? ST_FIN : ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_sts.done) begin
          state_nxt = ev_fin ? ST_FIN : ST_LOAD;
        end
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = state_r != ST_IDLE;
    out_strobe    = state_r == ST_FIN;
    out_is_prime  = res_r;
    div_ctl.start = state_r == ST_LOAD;
  end

  // datapath
  always_comb begin
    stage_nxt = stage_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt     = in_value;
          stage_nxt = SG_BY2;
          res_nxt   = in_value > VALUE_W'(1);
        end
      end
      ST_WAIT: begin
        if (div_sts.done) begin
          if (ev_fin) begin
            res_nxt = ev_prime;
          end else begin
            case (stage_r)
              SG_BY2:  stage_nxt = SG_BY3;
              SG_BY3:  stage_nxt = SG_BY5;
              SG_BY5: begin
                stage_nxt = SG_WHEEL;
                d_nxt     = VALUE_W'(FIRST_WHEEL);
                k_nxt     = '0;
              end
              default: begin
                d_nxt = d_r + VALUE_W'(wheel_gap(k_r));
                k_nxt = k_r + 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stage_r <= SG_BY2;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      k_r     <= k_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> rtl/core/wtd_checker.sv
// Port-level checks for the wheel-30 prime test, bound to the top level.
// Depends on wtd_pkg for the value type.
module wtd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input wtd_pkg::value_t in_value,
  input logic            out_strobe,
  input logic            out_is_prime
);
  import wtd_pkg::*;

  // one result beat per strobe, never two in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  a_strobe_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy)
    else $error("busy still high after result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("not idle after reset");

endmodule

bind wheel_trial_division_prime_test wtd_checker u_wtd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_value     (in_value),
  .out_strobe   (out_strobe),
  .out_is_prime (out_is_prime)
);
